[design/urb_pkg.sv]
// Shared constants and types for the dual-channel UART ring buffers.
`timescale 1ns / 1ps

package urb_pkg;

	localparam int RING_DEPTH   = 64;
	localparam int NUM_CHANNELS = 2;
	localparam int STORE_DEPTH  = NUM_CHANNELS * RING_DEPTH;

	localparam int PTR_W  = $clog2(RING_DEPTH);
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int BYTE_W = 8;
	localparam int CNT_W  = 6;
	localparam int STAT_W = 2;
	localparam int REQ_W  = 3;

	localparam logic [REQ_W-1:0] REQ_RX_BYTE  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_READ     = 3'd1;
	localparam logic [REQ_W-1:0] REQ_PEEK     = 3'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_TX_WRITE = 3'd4;
	localparam logic [REQ_W-1:0] REQ_TX_EMPTY = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// One access to a byte store: a write port and a read port.
	typedef struct packed {
		logic              we;
		addr_t             waddr;
		logic [BYTE_W-1:0] wdata;
		logic              re;
		addr_t             raddr;
	} mem_req_t;

	// What the control logic knows of a result before the store data returns.
	typedef struct packed {
		logic              valid;
		logic              dvalid;
		logic              from_tx;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  rx_count;
		logic              irq;
	} res_info_t;

endpackage

[design/urb_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module urb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/urb_ctrl.sv]
// Ring pointer state, request decode and byte store access for both rings.
`timescale 1ns / 1ps

module urb_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [urb_pkg::REQ_W-1:0]         req_type,
	input  logic                              channel,
	input  logic [urb_pkg::BYTE_W-1:0]        data_byte,
	output urb_pkg::mem_req_t                 rx_mem,
	output urb_pkg::mem_req_t                 tx_mem,
	output urb_pkg::res_info_t                res_s1
);

	urb_pkg::ptr_t rx_head_q [urb_pkg::NUM_CHANNELS];
	urb_pkg::ptr_t rx_tail_q [urb_pkg::NUM_CHANNELS];
	urb_pkg::ptr_t tx_head_q [urb_pkg::NUM_CHANNELS];
	urb_pkg::ptr_t tx_tail_q [urb_pkg::NUM_CHANNELS];
	logic          irq_q     [urb_pkg::NUM_CHANNELS];

	urb_pkg::ptr_t rx_head_d [urb_pkg::NUM_CHANNELS];
	urb_pkg::ptr_t rx_tail_d [urb_pkg::NUM_CHANNELS];
	urb_pkg::ptr_t tx_head_d [urb_pkg::NUM_CHANNELS];
	urb_pkg::ptr_t tx_tail_d [urb_pkg::NUM_CHANNELS];
	logic          irq_d     [urb_pkg::NUM_CHANNELS];

	urb_pkg::res_info_t res_d;

	logic          ch_ok;
	urb_pkg::ptr_t rh, rt, th, tt;
	urb_pkg::ptr_t rh_n, rt_n, th_n, tt_n;
	logic          irq_n;

	function automatic urb_pkg::ptr_t ring_next(input urb_pkg::ptr_t p);
		return (p == urb_pkg::PTR_W'(urb_pkg::RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic urb_pkg::addr_t ram_addr(input logic ch, input urb_pkg::ptr_t p);
		return urb_pkg::ADDR_W'(ch) * urb_pkg::ADDR_W'(urb_pkg::RING_DEPTH)
			+ urb_pkg::ADDR_W'(p);
	endfunction

	function automatic urb_pkg::ptr_t ring_count(input urb_pkg::ptr_t h,
			input urb_pkg::ptr_t t);
		logic [urb_pkg::PTR_W:0] wrap;
		wrap = {1'b0, h} + (urb_pkg::PTR_W + 1)'(urb_pkg::RING_DEPTH) - {1'b0, t};
		return (h >= t) ? h - t : wrap[urb_pkg::PTR_W-1:0];
	endfunction

	always_comb begin
		rx_head_d = rx_head_q;
		rx_tail_d = rx_tail_q;
		tx_head_d = tx_head_q;
		tx_tail_d = tx_tail_q;
		irq_d     = irq_q;

		ch_ok = 32'(channel) < urb_pkg::NUM_CHANNELS;
		rh = rx_head_q[channel];
		rt = rx_tail_q[channel];
		th = tx_head_q[channel];
		tt = tx_tail_q[channel];
		rh_n  = rh;
		rt_n  = rt;
		th_n  = th;
		tt_n  = tt;
		irq_n = irq_q[channel];

		rx_mem = '0;
		tx_mem = '0;
		rx_mem.waddr = ram_addr(channel, rh);
		rx_mem.wdata = data_byte;
		rx_mem.raddr = ram_addr(channel, rt);
		tx_mem.waddr = ram_addr(channel, th);
		tx_mem.wdata = data_byte;
		tx_mem.raddr = ram_addr(channel, tt);

		res_d = '0;
		res_d.valid  = accept;
		res_d.status = urb_pkg::ST_OK;

		if (!ch_ok) begin
			res_d.status = urb_pkg::ST_EMPTY;
		end else begin
			case (req_type)
				urb_pkg::REQ_RX_BYTE: begin
					if (ring_next(rh) != rt) begin
						rx_mem.we = accept;
						rh_n = ring_next(rh);
					end else begin
						res_d.status = urb_pkg::ST_FULL;
					end
				end
				urb_pkg::REQ_READ, urb_pkg::REQ_PEEK: begin
					if (rh == rt) begin
						res_d.status = urb_pkg::ST_EMPTY;
					end else begin
						rx_mem.re    = accept;
						res_d.dvalid = 1'b1;
						if (req_type == urb_pkg::REQ_READ) begin
							rt_n = ring_next(rt);
						end
					end
				end
				urb_pkg::REQ_CLEAR: begin
					rh_n = '0;
					rt_n = '0;
				end
				urb_pkg::REQ_TX_WRITE: begin
					if (ring_next(th) != tt) begin
						tx_mem.we = accept;
						th_n  = ring_next(th);
						irq_n = 1'b1;
					end else begin
						res_d.status = urb_pkg::ST_FULL;
					end
				end
				urb_pkg::REQ_TX_EMPTY: begin
					// The event only counts while the interrupt is enabled.
					if (irq_q[channel]) begin
						if (th == tt) begin
							irq_n = 1'b0;
							res_d.status = urb_pkg::ST_EMPTY;
						end else begin
							tx_mem.re     = accept;
							res_d.dvalid  = 1'b1;
							res_d.from_tx = 1'b1;
							tt_n = ring_next(tt);
						end
					end
				end
				default: begin
				end
			endcase
			res_d.rx_count = urb_pkg::CNT_W'(ring_count(rh_n, rt_n));
			res_d.irq      = irq_n;
			if (accept) begin
				rx_head_d[channel] = rh_n;
				rx_tail_d[channel] = rt_n;
				tx_head_d[channel] = th_n;
				tx_tail_d[channel] = tt_n;
				irq_d[channel]     = irq_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < urb_pkg::NUM_CHANNELS; i++) begin
				rx_head_q[i] <= '0;
				rx_tail_q[i] <= '0;
				tx_head_q[i] <= '0;
				tx_tail_q[i] <= '0;
				irq_q[i]     <= 1'b0;
			end
			res_s1 <= '0;
		end else begin
			rx_head_q <= rx_head_d;
			rx_tail_q <= rx_tail_d;
			tx_head_q <= tx_head_d;
			tx_tail_q <= tx_tail_d;
			irq_q     <= irq_d;
			res_s1    <= res_d;
		end
	end

	// Every accepted request yields exactly one result in the following cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_s1.valid == $past(accept))
		else $error("result strobe does not follow the accepted request");

	// A byte is only reported together with an ok status.
	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_s1.valid && res_s1.dvalid) |-> (res_s1.status == urb_pkg::ST_OK))
		else $error("byte reported with an error status");

	// A store is never written and read by the same request.
	a_rx_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(rx_mem.we && rx_mem.re))
		else $error("receive store written and read together");

	// A store read is only started for a request that returns a byte.
	a_read_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_mem.re || tx_mem.re) |=> (res_s1.valid && res_s1.dvalid))
		else $error("store read without a byte in the result");

	// The receive head and transmit tail pointers of channel 0 stay inside the ring.
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(rx_head_q[0]) < urb_pkg::RING_DEPTH) && (32'(tx_tail_q[0]) < urb_pkg::RING_DEPTH))
		else $error("ring pointer out of range");

endmodule

[design/uart_rx_tx_ring_buffers.sv]
// Top level of the dual-channel UART receive and transmit ring buffers.
//
//  channel   signals                                   handshake
//  request   req_type, channel, data_byte              start && !busy
//  result    data_out, data_valid, status, rx_count,   done, one cycle
//            tx_irq_enable
//
// Each request is decoded and the pointers updated in the cycle it is taken;
// the byte store read completes in the next cycle, when done is high.
// A request may be taken in every cycle, so busy is held low.
// Reset clears every pointer and interrupt enable; the byte stores hold no
// reset value and are read only between tail and head.
// The receiver of results cannot stall; each result shows for one cycle.
`timescale 1ns / 1ps

module uart_rx_tx_ring_buffers (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [urb_pkg::REQ_W-1:0]    req_type,
	input  logic                         channel,
	input  logic [urb_pkg::BYTE_W-1:0]   data_byte,
	output logic                         done,
	output logic [urb_pkg::BYTE_W-1:0]   data_out,
	output logic                         data_valid,
	output logic [urb_pkg::STAT_W-1:0]   status,
	output logic [urb_pkg::CNT_W-1:0]    rx_count,
	output logic                         tx_irq_enable
);

	urb_pkg::mem_req_t  rx_mem;
	urb_pkg::mem_req_t  tx_mem;
	urb_pkg::res_info_t res_s1;
	logic [urb_pkg::BYTE_W-1:0] rx_rdata;
	logic [urb_pkg::BYTE_W-1:0] tx_rdata;

	assign busy = 1'b0;

	urb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (start && !busy),
		.req_type  (req_type),
		.channel   (channel),
		.data_byte (data_byte),
		.rx_mem    (rx_mem),
		.tx_mem    (tx_mem),
		.res_s1    (res_s1)
	);

	urb_ram #(
		.WIDTH (urb_pkg::BYTE_W),
		.DEPTH (urb_pkg::STORE_DEPTH)
	) u_rx_store (
		.clk   (clk),
		.we    (rx_mem.we),
		.waddr (rx_mem.waddr),
		.wdata (rx_mem.wdata),
		.re    (rx_mem.re),
		.raddr (rx_mem.raddr),
		.rdata (rx_rdata)
	);

	urb_ram #(
		.WIDTH (urb_pkg::BYTE_W),
		.DEPTH (urb_pkg::STORE_DEPTH)
	) u_tx_store (
		.clk   (clk),
		.we    (tx_mem.we),
		.waddr (tx_mem.waddr),
		.wdata (tx_mem.wdata),
		.re    (tx_mem.re),
		.raddr (tx_mem.raddr),
		.rdata (tx_rdata)
	);

	assign done          = res_s1.valid;
	assign data_valid    = res_s1.dvalid;
	assign data_out      = !res_s1.dvalid ? '0 : (res_s1.from_tx ? tx_rdata : rx_rdata);
	assign status        = res_s1.status;
	assign rx_count      = res_s1.rx_count;
	assign tx_irq_enable = res_s1.irq;

endmodule

[test/uart_rx_tx_ring_buffers_tb.sv]
// Self-checking testbench for the dual-channel UART receive and transmit ring buffers.
`timescale 1ns / 1ps

module uart_rx_tx_ring_buffers_tb;

	localparam logic [urb_pkg::REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
	localparam logic [urb_pkg::REQ_W-1:0] REQ_UNUSED_7 = 3'd7;
	localparam int ITEM_TARGET  = 1450;
	localparam int STALL_LIMIT  = 1000;
	localparam int PRINT_LIMIT  = 40;

	typedef struct {
		logic [urb_pkg::BYTE_W-1:0] data_out;
		logic                       data_valid;
		logic [urb_pkg::STAT_W-1:0] status;
		logic [urb_pkg::CNT_W-1:0]  rx_count;
		logic                       tx_irq_enable;
	} ring_outcome_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic [urb_pkg::REQ_W-1:0]    req_type = '0;
	logic                         channel = 1'b0;
	logic [urb_pkg::BYTE_W-1:0]   data_byte = '0;
	logic                         busy;
	logic                         done;
	logic [urb_pkg::BYTE_W-1:0]   data_out;
	logic                         data_valid;
	logic [urb_pkg::STAT_W-1:0]   status;
	logic [urb_pkg::CNT_W-1:0]    rx_count;
	logic                         tx_irq_enable;

	// Model of both rings of every channel.
	logic [urb_pkg::BYTE_W-1:0] rx_ring [urb_pkg::NUM_CHANNELS][urb_pkg::RING_DEPTH];
	logic [urb_pkg::BYTE_W-1:0] tx_ring [urb_pkg::NUM_CHANNELS][urb_pkg::RING_DEPTH];
	urb_pkg::ptr_t              rx_wr_ptr [urb_pkg::NUM_CHANNELS];
	urb_pkg::ptr_t              rx_rd_ptr [urb_pkg::NUM_CHANNELS];
	urb_pkg::ptr_t              tx_wr_ptr [urb_pkg::NUM_CHANNELS];
	urb_pkg::ptr_t              tx_rd_ptr [urb_pkg::NUM_CHANNELS];
	logic                       tx_irq_model [urb_pkg::NUM_CHANNELS];

	ring_outcome_t pending_outcomes [$];
	int            mismatch_count = 0;
	int            requests_sent = 0;
	int            stall_cycles = 0;
	bit            gapless = 1'b0;

	uart_rx_tx_ring_buffers dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.channel      (channel),
		.data_byte    (data_byte),
		.done         (done),
		.data_out     (data_out),
		.data_valid   (data_valid),
		.status       (status),
		.rx_count     (rx_count),
		.tx_irq_enable(tx_irq_enable)
	);

	always #6 clk = ~clk;

	function automatic urb_pkg::ptr_t ring_next(urb_pkg::ptr_t p);
		return urb_pkg::ptr_t'((p + 1) % urb_pkg::RING_DEPTH);
	endfunction

	// Applies one request to the model rings and returns the result it must give.
	function automatic ring_outcome_t ring_access_outcome(logic [urb_pkg::REQ_W-1:0] req,
			logic ch, logic [urb_pkg::BYTE_W-1:0] value);
		ring_outcome_t o;
		urb_pkg::ptr_t nx;
		o = '{default: '0};
		o.status = urb_pkg::ST_OK;
		case (req)
			urb_pkg::REQ_RX_BYTE: begin
				nx = ring_next(rx_wr_ptr[ch]);
				if (nx != rx_rd_ptr[ch]) begin
					rx_ring[ch][rx_wr_ptr[ch]] = value;
					rx_wr_ptr[ch] = nx;
				end else begin
					o.status = urb_pkg::ST_FULL;
				end
			end
			urb_pkg::REQ_READ, urb_pkg::REQ_PEEK: begin
				if (rx_wr_ptr[ch] == rx_rd_ptr[ch]) begin
					o.status = urb_pkg::ST_EMPTY;
				end else begin
					o.data_out = rx_ring[ch][rx_rd_ptr[ch]];
					o.data_valid = 1'b1;
					if (req == urb_pkg::REQ_READ)
						rx_rd_ptr[ch] = ring_next(rx_rd_ptr[ch]);
				end
			end
			urb_pkg::REQ_CLEAR: begin
				rx_wr_ptr[ch] = '0;
				rx_rd_ptr[ch] = '0;
			end
			urb_pkg::REQ_TX_WRITE: begin
				nx = ring_next(tx_wr_ptr[ch]);
				if (nx != tx_rd_ptr[ch]) begin
					tx_ring[ch][tx_wr_ptr[ch]] = value;
					tx_wr_ptr[ch] = nx;
					tx_irq_model[ch] = 1'b1;
				end else begin
					o.status = urb_pkg::ST_FULL;
				end
			end
			urb_pkg::REQ_TX_EMPTY: begin
				// The event is only acted on while the interrupt is enabled.
				if (tx_irq_model[ch]) begin
					if (tx_wr_ptr[ch] == tx_rd_ptr[ch]) begin
						tx_irq_model[ch] = 1'b0;
						o.status = urb_pkg::ST_EMPTY;
					end else begin
						o.data_out = tx_ring[ch][tx_rd_ptr[ch]];
						o.data_valid = 1'b1;
						tx_rd_ptr[ch] = ring_next(tx_rd_ptr[ch]);
					end
				end
			end
			default: ;
		endcase
		o.rx_count = urb_pkg::CNT_W'((urb_pkg::RING_DEPTH + rx_wr_ptr[ch] - rx_rd_ptr[ch])
			% urb_pkg::RING_DEPTH);
		o.tx_irq_enable = tx_irq_model[ch];
		return o;
	endfunction

	function automatic int idle_gap();
		int r;
		r = $urandom_range(99);
		if (gapless)
			return 0;
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(2, 1);
		if (r < 97)
			return $urandom_range(8, 3);
		return $urandom_range(40, 15);
	endfunction

	task automatic report_mismatch(string what);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t ns: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// Called just after a rising edge; returns just after a rising edge.
	task automatic send_request(logic [urb_pkg::REQ_W-1:0] req, logic ch,
			logic [urb_pkg::BYTE_W-1:0] value);
		int gap;
		start <= 1'b1;
		req_type <= req;
		channel <= ch;
		data_byte <= value;
		do
			@(posedge clk);
		while (busy);
		pending_outcomes.push_back(ring_access_outcome(req, ch, value));
		requests_sent++;
		gap = idle_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic test_directed();
		send_request(urb_pkg::REQ_READ, 1'b0, 8'h11);
		send_request(urb_pkg::REQ_PEEK, 1'b1, 8'hEE);
		send_request(urb_pkg::REQ_TX_EMPTY, 1'b0, 8'h00);
		send_request(urb_pkg::REQ_RX_BYTE, 1'b0, 8'h00);
		send_request(urb_pkg::REQ_RX_BYTE, 1'b0, 8'hFF);
		send_request(urb_pkg::REQ_PEEK, 1'b0, 8'h77);
		send_request(urb_pkg::REQ_READ, 1'b0, 8'h88);
		send_request(urb_pkg::REQ_READ, 1'b0, 8'h00);
		send_request(urb_pkg::REQ_READ, 1'b0, 8'hFF);
		send_request(urb_pkg::REQ_TX_WRITE, 1'b1, 8'hA5);
		send_request(urb_pkg::REQ_TX_WRITE, 1'b1, 8'h5A);
		send_request(urb_pkg::REQ_TX_EMPTY, 1'b1, 8'h00);
		send_request(urb_pkg::REQ_TX_EMPTY, 1'b1, 8'hFF);
		send_request(urb_pkg::REQ_TX_EMPTY, 1'b1, 8'h00);
		send_request(urb_pkg::REQ_TX_EMPTY, 1'b1, 8'h00);
		send_request(urb_pkg::REQ_RX_BYTE, 1'b1, 8'h3C);
		send_request(urb_pkg::REQ_RX_BYTE, 1'b1, 8'hC3);
		send_request(urb_pkg::REQ_CLEAR, 1'b1, 8'hFF);
		send_request(urb_pkg::REQ_PEEK, 1'b1, 8'h00);
		send_request(REQ_UNUSED_6, 1'b0, 8'hFF);
		send_request(REQ_UNUSED_7, 1'b1, 8'h00);
		send_request(urb_pkg::REQ_RX_BYTE, 1'b0, 8'h81);
		send_request(urb_pkg::REQ_READ, 1'b0, 8'h00);
	endtask

	// Overfills the receive ring so that bytes are dropped, then drains it past empty.
	task automatic test_rx_overflow(logic ch);
		send_request(urb_pkg::REQ_CLEAR, ch, 8'($urandom));
		repeat (urb_pkg::RING_DEPTH + 1) send_request(urb_pkg::REQ_RX_BYTE, ch, 8'($urandom));
		send_request(urb_pkg::REQ_PEEK, ch, 8'($urandom));
		repeat (urb_pkg::RING_DEPTH) send_request(urb_pkg::REQ_READ, ch, 8'($urandom));
	endtask

	// Overfills the transmit ring so that writes are refused, then drains it until
	// the interrupt enable drops.
	task automatic test_tx_overflow(logic ch);
		repeat (urb_pkg::RING_DEPTH + 1)
			send_request(urb_pkg::REQ_TX_WRITE, ch, 8'($urandom));
		repeat (urb_pkg::RING_DEPTH + 2)
			send_request(urb_pkg::REQ_TX_EMPTY, ch, 8'($urandom));
	endtask

	function automatic logic [urb_pkg::REQ_W-1:0] pick_request(int mode);
		int r;
		r = $urandom_range(99);
		case (mode)
			0: begin
				// Filling: rings tend towards full.
				if (r < 45) return urb_pkg::REQ_RX_BYTE;
				if (r < 75) return urb_pkg::REQ_TX_WRITE;
				if (r < 85) return urb_pkg::REQ_PEEK;
				if (r < 93) return urb_pkg::REQ_READ;
				if (r < 99) return urb_pkg::REQ_TX_EMPTY;
				return urb_pkg::REQ_CLEAR;
			end
			1: begin
				// Draining: rings tend towards empty.
				if (r < 10) return urb_pkg::REQ_RX_BYTE;
				if (r < 20) return urb_pkg::REQ_TX_WRITE;
				if (r < 55) return urb_pkg::REQ_READ;
				if (r < 65) return urb_pkg::REQ_PEEK;
				if (r < 95) return urb_pkg::REQ_TX_EMPTY;
				if (r < 97) return urb_pkg::REQ_CLEAR;
				return (r < 98) ? REQ_UNUSED_6 : REQ_UNUSED_7;
			end
			default: begin
				if (r < 4) return urb_pkg::REQ_CLEAR;
				if (r < 8) return (r < 6) ? REQ_UNUSED_6 : REQ_UNUSED_7;
				return urb_pkg::REQ_W'($urandom_range(urb_pkg::REQ_TX_EMPTY,
					urb_pkg::REQ_RX_BYTE));
			end
		endcase
	endfunction

	task automatic test_random_bursts();
		int mode;
		int length;
		logic main_ch;
		logic ch;
		while (requests_sent < ITEM_TARGET) begin
			mode = $urandom_range(2);
			length = $urandom_range(90, 20);
			main_ch = 1'($urandom);
			gapless = ($urandom_range(3) == 0);
			repeat (length) begin
				ch = ($urandom_range(9) < 8) ? main_ch : ~main_ch;
				send_request(pick_request(mode), ch, 8'($urandom));
			end
		end
		gapless = 1'b0;
	endtask

	always @(posedge clk) begin : check_results
		ring_outcome_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("result with no request pending");
			end else begin
				want = pending_outcomes.pop_front();
				if (data_out !== want.data_out)
					report_mismatch($sformatf("data_out %h, expected %h",
						data_out, want.data_out));
				if (data_valid !== want.data_valid)
					report_mismatch($sformatf("data_valid %b, expected %b",
						data_valid, want.data_valid));
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						status, want.status));
				if (rx_count !== want.rx_count)
					report_mismatch($sformatf("rx_count %0d, expected %0d",
						rx_count, want.rx_count));
				if (tx_irq_enable !== want.tx_irq_enable)
					report_mismatch($sformatf("tx_irq_enable %b, expected %b",
						tx_irq_enable, want.tx_irq_enable));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("uart_rx_tx_ring_buffers_tb: done, errors");
			$finish;
		end
	end

	initial begin
		for (int c = 0; c < urb_pkg::NUM_CHANNELS; c++) begin
			rx_wr_ptr[c] = '0;
			rx_rd_ptr[c] = '0;
			tx_wr_ptr[c] = '0;
			tx_rd_ptr[c] = '0;
			tx_irq_model[c] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_rx_overflow(1'($urandom));
		test_tx_overflow(1'($urandom));
		test_random_bursts();

		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("uart_rx_tx_ring_buffers_tb: done, clean");
		else
			$display("uart_rx_tx_ring_buffers_tb: done, errors");
		$finish;
	end

endmodule

[filelist.f]
design/urb_pkg.sv
design/urb_ram.sv
design/urb_ctrl.sv
design/uart_rx_tx_ring_buffers.sv
test/uart_rx_tx_ring_buffers_tb.sv
